FILE: hw/rtl/ccvlc_pkg.sv
// Shared constants and types for the control character visualizer with line clipping.
package ccvlc_pkg;

   // Character codes used by the escape logic.
   localparam logic [7:0] NL_CODE      = 8'd10;
   localparam logic [7:0] DEL_CODE     = 8'd127;
   localparam logic [7:0] CTRL_TOP     = 8'd31;
   localparam logic [7:0] CARET_OFFSET = 8'd64;
   localparam logic [7:0] HIGH_START   = 8'd128;
   localparam logic [7:0] CARET_CHAR   = 8'd94;
   localparam logic [7:0] DOLLAR_CHAR  = 8'd36;
   localparam logic [7:0] QMARK_CHAR   = 8'd63;

   // Register map: one register, line_limit at word 0.
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic        CSR_LINE_LIMIT = 1'b0;
   localparam logic [7:0]  LIMIT_RESET    = 8'd72;

   // Result queue holds the item at the output plus room for one two-character escape.
   localparam int unsigned QUEUE_DEPTH = 3;

   // One result item.
   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       last;
      logic       differs;
   } result_type;

endpackage

FILE: hw/rtl/ccvlc_if.sv
// Valid/ready channel interfaces for the input bytes and the result characters.
interface ccvlc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_mark;

   modport source (output valid, output in_byte, output end_mark, input ready);
   modport sink   (input valid, input in_byte, input end_mark, output ready);
endinterface

interface ccvlc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       char_valid;
   logic       last;
   logic       differs;

   modport source (output valid, output out_char, output char_valid, output last,
                   output differs, input ready);
   modport sink   (input valid, input out_char, input char_valid, input last,
                   input differs, output ready);
endinterface

FILE: hw/rtl/control_char_visualizer_line_clip.sv
// Control character visualizer: escapes control bytes, drops high bytes, clips long lines, reports changes.
//
// Each byte item is decoded in the cycle it is accepted and its zero, one or two result
// items are written into a three-entry result queue whose head drives the rsp channel.
// The block accepts one item per cycle while at most one result is waiting, so plain text
// streams at one byte per clock while rsp_chan is ready; a two-character escape (caret
// pair, "$" plus newline, or "^" plus newline at a clip) fills two queue entries and the
// input waits until at most one result is left. An end_mark item yields a single report
// with char_valid low and the sticky differs flag, then clears the column, skip and flag state.
// line_limit is written through the APB port at byte address 0 and is kept across end_mark items.
module control_char_visualizer_line_clip (
   input  logic                                 clock,
   input  logic                                 reset,
   ccvlc_req_if.sink                            req_chan,
   ccvlc_rsp_if.source                          rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ccvlc_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   logic [7:0]             line_limit_ff;
   logic [7:0]             column_ff, column_in;
   logic                   skip_ff, skip_in;
   logic                   flag_ff, flag_in;
   ccvlc_pkg::result_type  queue_ff [ccvlc_pkg::QUEUE_DEPTH];
   ccvlc_pkg::result_type  queue_in [ccvlc_pkg::QUEUE_DEPTH];
   logic [1:0]             count_ff, count_in;
   logic [1:0]             base;
   logic [1:0]             res_count;
   ccvlc_pkg::result_type  res0, res1;
   logic [7:0]             a_char, b_char;
   logic                   accept, pop;
   logic                   csr_write;
   logic [7:0]             c;
   logic [8:0]             column_next;

   // Configuration register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == ccvlc_pkg::CSR_LINE_LIMIT) ? {24'd0, line_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= ccvlc_pkg::LIMIT_RESET;
      end else if (csr_write && paddr[2] == ccvlc_pkg::CSR_LINE_LIMIT) begin
         line_limit_ff <= pwdata[7:0];
      end
   end

   // Handshakes.
   assign req_chan.ready = (count_ff <= 2'd1);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign c              = req_chan.in_byte;
   assign column_next    = {1'b0, column_ff} + 9'd1;

   // Decode one byte into its results and the next line state.
   always_comb begin
      column_in = column_ff;
      skip_in   = skip_ff;
      flag_in   = flag_ff;
      res_count = 2'd0;
      a_char    = 8'd0;
      b_char    = 8'd0;
      res0      = '0;
      res1      = '0;
      if (req_chan.end_mark) begin
         res_count = 2'd1;
         res0      = '{out_char: 8'd0, char_valid: 1'b0, last: 1'b1, differs: flag_ff};
         column_in = 8'd0;
         skip_in   = 1'b0;
         flag_in   = 1'b0;
      end else if (skip_ff) begin
         if (c == ccvlc_pkg::NL_CODE) begin
            skip_in = 1'b0;
         end
      end else if (column_ff >= line_limit_ff) begin
         column_in = 8'd0;
         if (c != ccvlc_pkg::NL_CODE) begin
            flag_in = 1'b1;
            skip_in = 1'b1;
         end
         res_count = 2'd1;
         res0      = '{out_char: ccvlc_pkg::NL_CODE, char_valid: 1'b1, last: 1'b1,
                       differs: flag_in};
      end else if (c <= ccvlc_pkg::CTRL_TOP || c == ccvlc_pkg::DEL_CODE) begin
         if (c != ccvlc_pkg::NL_CODE && column_next >= {1'b0, line_limit_ff}) begin
            // Only one column left: show a bare caret and clip the line.
            a_char    = ccvlc_pkg::CARET_CHAR;
            b_char    = ccvlc_pkg::NL_CODE;
            column_in = 8'd0;
            flag_in   = 1'b1;
            skip_in   = 1'b1;
         end else if (c == ccvlc_pkg::NL_CODE) begin
            a_char    = ccvlc_pkg::DOLLAR_CHAR;
            b_char    = ccvlc_pkg::NL_CODE;
            column_in = 8'd0;
         end else begin
            a_char    = ccvlc_pkg::CARET_CHAR;
            b_char    = (c == ccvlc_pkg::DEL_CODE) ? ccvlc_pkg::QMARK_CHAR
                                                   : c + ccvlc_pkg::CARET_OFFSET;
            column_in = column_ff + 8'd2;
            flag_in   = 1'b1;
         end
         res_count = 2'd2;
         res0      = '{out_char: a_char, char_valid: 1'b1, last: 1'b0, differs: flag_in};
         res1      = '{out_char: b_char, char_valid: 1'b1, last: 1'b1, differs: flag_in};
      end else if (c >= ccvlc_pkg::HIGH_START) begin
         flag_in = 1'b1;
      end else begin
         column_in = column_next[7:0];
         res_count = 2'd1;
         res0      = '{out_char: c, char_valid: 1'b1, last: 1'b1, differs: flag_ff};
      end
   end

   // Result queue: shift out the head on a pop, append new results behind the rest.
   always_comb begin
      base = count_ff - {1'b0, pop};
      for (int i = 0; i < ccvlc_pkg::QUEUE_DEPTH; i++) begin
         if (pop && i < ccvlc_pkg::QUEUE_DEPTH - 1) begin
            queue_in[i] = queue_ff[i+1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (accept && res_count != 2'd0 && 2'(i) == base) begin
            queue_in[i] = res0;
         end
         if (accept && res_count == 2'd2 && 2'(i) == base + 2'd1) begin
            queue_in[i] = res1;
         end
      end
      count_in = accept ? base + res_count : base;
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   // Line state and queue fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 8'd0;
         skip_ff   <= 1'b0;
         flag_ff   <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            column_ff <= column_in;
            skip_ff   <= skip_in;
            flag_ff   <= flag_in;
         end
      end
   end

   // Output channel driven from the queue head.
   assign rsp_chan.valid      = (count_ff != 2'd0);
   assign rsp_chan.out_char   = queue_ff[0].out_char;
   assign rsp_chan.char_valid = queue_ff[0].char_valid;
   assign rsp_chan.last       = queue_ff[0].last;
   assign rsp_chan.differs    = queue_ff[0].differs;

`ifndef NO_ASSERTIONS
   // The queue never holds more results than it has entries.
   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd3)
      else $error("result queue overflow");

   // An end report leaves the line state cleared.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.end_mark |=> column_ff == 8'd0 && !skip_ff && !flag_ff)
      else $error("state not cleared after end of stream");

   // The sticky flag only falls through an end-of-stream item.
   assert property (@(posedge clock) disable iff (reset)
      $fell(flag_ff) |-> $past(accept && req_chan.end_mark))
      else $error("differs flag cleared without end of stream");

   // A result with char_valid low is always the last of its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.char_valid |-> rsp_chan.last)
      else $error("end report not marked last");
`endif

endmodule
